@@ rtl/swm_pkg.sv @@
// Sliding window median: shared constants, word types and control structs.
// Used by every module of the block; depends on nothing.
`default_nettype none

package swm_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int WS_W       = 7;
    localparam int GRP        = 8;
    localparam int N_GRP      = (MAX_WINDOW + GRP - 1) / GRP;

    typedef struct packed {
        logic signed [31:0] sample;
        logic               last_sample;
    } t_in_word;

    typedef struct packed {
        logic signed [32:0] median_doubled;
        logic               sequence_end;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_REMOVE,
        S_MED_SEL,
        S_MED_OUT
    } t_state;

    typedef struct packed {
        logic latch;
        logic ring_rd;
        logic remove;
        logic insert;
        logic med_sel;
        logic med_load;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic fill_ge_k;
        logic fill_to_k;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ rtl/swm_ctrl.sv @@
// Sliding window median: sequencing state machine.
// Depends on swm_pkg; drives the datapath through t_cmd, watches t_sts.
`default_nettype none

module swm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire swm_pkg::t_sts i_sts,
    output swm_pkg::t_cmd      o_cmd
);

    swm_pkg::t_state r_state;
    swm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            swm_pkg::S_IDLE: begin
                if (i_in_valid) n_state = swm_pkg::S_CHECK;
            end
            swm_pkg::S_CHECK: begin
                if (i_sts.fill_ge_k)      n_state = swm_pkg::S_REMOVE;
                else if (i_sts.fill_to_k) n_state = swm_pkg::S_MED_SEL;
                else                      n_state = swm_pkg::S_IDLE;
            end
            swm_pkg::S_REMOVE:  n_state = swm_pkg::S_CHECK;
            swm_pkg::S_MED_SEL: n_state = swm_pkg::S_MED_OUT;
            swm_pkg::S_MED_OUT: begin
                if (i_sts.out_free) n_state = swm_pkg::S_IDLE;
            end
            default: n_state = swm_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            swm_pkg::S_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.latch = i_in_valid;
            end
            swm_pkg::S_CHECK: begin
                o_cmd.ring_rd = i_sts.fill_ge_k;
                o_cmd.insert  = !i_sts.fill_ge_k;
                o_cmd.finish  = !i_sts.fill_ge_k && !i_sts.fill_to_k;
            end
            swm_pkg::S_REMOVE:  o_cmd.remove  = 1'b1;
            swm_pkg::S_MED_SEL: o_cmd.med_sel = 1'b1;
            swm_pkg::S_MED_OUT: begin
                o_cmd.med_load = i_sts.out_free;
                o_cmd.finish   = i_sts.out_free;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/swm_dp.sv @@
// Sliding window median: arrival ring, sorted cell row, median pick and output register.
// Depends on swm_pkg; commanded by swm_ctrl.
`default_nettype none

module swm_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [swm_pkg::WS_W-1:0]      i_cfg_wr_data,
    input  wire swm_pkg::t_in_word             i_in_word,
    input  wire swm_pkg::t_cmd                 i_cmd,
    output swm_pkg::t_sts                      o_sts,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output swm_pkg::t_out_word                 o_out_word
);

    localparam int CNT_W = swm_pkg::CNT_W;
    localparam int IDX_W = swm_pkg::IDX_W;
    localparam int MAXW  = swm_pkg::MAX_WINDOW;

    // configuration and per-word latches
    logic [swm_pkg::WS_W-1:0] r_window_size;
    logic [CNT_W-1:0]         r_k;
    logic [CNT_W-1:0]         n_k;
    logic signed [31:0]       r_sample;
    logic                     r_last;

    // counters
    logic [CNT_W-1:0] r_fill;
    logic [IDX_W-1:0] r_pos;

    // arrival ring
    logic signed [31:0] r_ring [MAXW];
    logic signed [31:0] r_ring_q;
    logic [IDX_W-1:0]   oldest_idx;

    // sorted cell row
    logic signed [31:0] r_cell [MAXW];
    logic signed [31:0] n_cell [MAXW];

    // median pick
    logic [CNT_W-1:0]   lo_idx;
    logic [CNT_W-1:0]   hi_idx;
    logic [31:0]        r_part_lo [swm_pkg::N_GRP];
    logic [31:0]        r_part_hi [swm_pkg::N_GRP];
    logic [31:0]        n_part_lo [swm_pkg::N_GRP];
    logic [31:0]        n_part_hi [swm_pkg::N_GRP];
    logic signed [31:0] med_lo;
    logic signed [31:0] med_hi;

    logic               r_out_valid;
    swm_pkg::t_out_word r_out_word;
    logic               out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= swm_pkg::WS_W'(3);
        end else if (i_cfg_wr_en) begin
            r_window_size <= i_cfg_wr_data;
        end
    end

    // zero acts as one, oversize saturates
    always_comb begin
        if (r_window_size == '0) begin
            n_k = CNT_W'(1);
        end else if (32'(r_window_size) > MAXW) begin
            n_k = CNT_W'(MAXW);
        end else begin
            n_k = CNT_W'(r_window_size);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_k      <= n_k;
            r_sample <= i_in_word.sample;
            r_last   <= i_in_word.last_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_pos  <= '0;
        end else if (i_cmd.finish && r_last) begin
            r_fill <= '0;
            r_pos  <= '0;
        end else if (i_cmd.insert) begin
            r_fill <= r_fill + 1'b1;
            r_pos  <= r_pos + 1'b1;
        end else if (i_cmd.remove) begin
            r_fill <= r_fill - 1'b1;
        end
    end

    assign oldest_idx = r_pos - r_fill[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            r_ring[r_pos] <= r_sample;
        end
        if (i_cmd.ring_rd) begin
            r_ring_q <= r_ring[oldest_idx];
        end
    end

    // Remove: the evicted value is always held, and the first cell >= it is its
    // first copy, so every valid cell from there on pulls from its upper neighbour.
    // Insert: cells above the new value move up one, the gap takes the value.
    always_comb begin
        for (int i = 0; i < MAXW; i++) begin
            n_cell[i] = r_cell[i];
            if (i_cmd.remove) begin
                if (i + 1 < MAXW) begin
                    if ((r_cell[i] >= r_ring_q) && (32'(i + 1) < 32'(r_fill))) begin
                        n_cell[i] = r_cell[i + 1];
                    end
                end
            end else if (i_cmd.insert) begin
                if ((i > 0) && (32'(i - 1) < 32'(r_fill)) && (r_cell[(i > 0) ? i - 1 : 0]
                        > r_sample)) begin
                    n_cell[i] = r_cell[(i > 0) ? i - 1 : 0];
                end else if ((32'(i) == 32'(r_fill)) ||
                             ((32'(i) < 32'(r_fill)) && (r_cell[i] > r_sample))) begin
                    n_cell[i] = r_sample;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAXW; i++) begin
            r_cell[i] <= n_cell[i];
        end
    end

    // the two middle positions; equal for an odd window
    assign lo_idx = (r_k - 1'b1) >> 1;
    assign hi_idx = r_k >> 1;

    // first level of the pick: masked OR per group of cells
    always_comb begin
        for (int g = 0; g < swm_pkg::N_GRP; g++) begin
            n_part_lo[g] = '0;
            n_part_hi[g] = '0;
            for (int j = 0; j < swm_pkg::GRP; j++) begin
                if (g * swm_pkg::GRP + j < MAXW) begin
                    if (CNT_W'(g * swm_pkg::GRP + j) == lo_idx) begin
                        n_part_lo[g] = n_part_lo[g]
                                     | r_cell[(g * swm_pkg::GRP + j) % MAXW];
                    end
                    if (CNT_W'(g * swm_pkg::GRP + j) == hi_idx) begin
                        n_part_hi[g] = n_part_hi[g]
                                     | r_cell[(g * swm_pkg::GRP + j) % MAXW];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.med_sel) begin
            for (int g = 0; g < swm_pkg::N_GRP; g++) begin
                r_part_lo[g] <= n_part_lo[g];
                r_part_hi[g] <= n_part_hi[g];
            end
        end
    end

    always_comb begin
        med_lo = '0;
        med_hi = '0;
        for (int g = 0; g < swm_pkg::N_GRP; g++) begin
            med_lo = med_lo | r_part_lo[g];
            med_hi = med_hi | r_part_hi[g];
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.med_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.med_load) begin
            r_out_word.median_doubled <= {med_lo[31], med_lo} + {med_hi[31], med_hi};
            r_out_word.sequence_end   <= r_last;
        end
    end

    assign o_sts.fill_ge_k = (r_fill >= r_k);
    assign o_sts.fill_to_k = ({1'b0, r_fill} + 1'b1) == {1'b0, r_k};
    assign o_sts.out_free  = out_free;
    assign o_out_valid     = r_out_valid;
    assign o_out_word      = r_out_word;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(MAXW))
        else $error("window fill beyond capacity");

    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |-> (r_fill < r_k))
        else $error("insert into a full window");

    a_remove_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.remove |-> (r_fill != '0) && $past(i_cmd.ring_rd))
        else $error("eviction without a held sample or ring read");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.med_load |-> out_free)
        else $error("result would overwrite a waiting word");
`endif

endmodule

`default_nettype wire

@@ rtl/sliding_window_median_unit.sv @@
// Sliding window median: top level joining swm_ctrl and swm_dp.
// Depends on swm_pkg, swm_ctrl, swm_dp.
//
// Usage
//   Input channel i_in_valid / o_in_stall / i_in_word carries one signed sample
//   and a last-sample flag per word. Output channel o_out_valid / i_out_stall /
//   o_out_word carries twice the window median and a sequence-end flag.
//   i_cfg_wr_en / i_cfg_wr_data set the window size (0 acts as 1, above 64
//   saturates); write it only while the block is idle. Reset value is 3.
//   A result appears only for samples at which the window is exactly full.
// Sequence
//   One word at a time: latch, then evict the oldest word while the window is
//   full (ring read, then remove from the sorted cell row), then insert into
//   the row. The word that fills the window then has its median picked and
//   loaded into the output register once the slot is free. Each surplus
//   eviction after a window shrink adds one ring read and one removal.
// Reset / stall
//   Synchronous reset empties the window and drops any waiting result; the
//   ring and cell row contents are left as they are. A new word is accepted
//   while a result still waits; only a second result waits for the slot.
`default_nettype none

module sliding_window_median_unit (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_wr_en,
    input  wire logic [swm_pkg::WS_W-1:0] i_cfg_wr_data,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire swm_pkg::t_in_word        i_in_word,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output swm_pkg::t_out_word            o_out_word
);

    swm_pkg::t_cmd cmd;
    swm_pkg::t_sts sts;

    // sequencer: accept, evict while full, insert, pick median
    swm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // storage, sorted row and output register
    swm_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_word     (i_in_word),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_word    (o_out_word)
    );

endmodule

`default_nettype wire

@@ tb/sliding_window_median_unit_test.sv @@
// Self-checking testbench for sliding_window_median_unit: predicts doubled medians and
// compares each result word with the next one expected, under random gaps and stalls.
// Depends on swm_pkg and sliding_window_median_unit.
`default_nettype none

module sliding_window_median_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Sample extremes used by the directed tests.
    localparam logic signed [31:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAMPLE_MIN = 32'sh8000_0000;

    // Wait after the last result, so that a word that yields no result can finish.
    localparam int IDLE_CYCLES  = 20;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int RAND_ITEMS   = 1550;
    localparam int MAX_REPORTS  = 40;
    // Hard run limit in ns; the clock period is 4 ns.
    localparam longint RUN_LIMIT_NS = 4_000_000;

    // DUT signals; the inputs are driven to known values from time zero.
    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        i_cfg_wr_en   = 1'b0;
    logic [swm_pkg::WS_W-1:0]    i_cfg_wr_data = '0;
    logic                        i_in_valid    = 1'b0;
    logic                        o_in_stall;
    swm_pkg::t_in_word           i_in_word     = '0;
    logic                        o_out_valid;
    logic                        i_out_stall   = 1'b0;
    swm_pkg::t_out_word          o_out_word;

    // Testbench state.
    bit                          gaps_on     = 1'b1;   // random idling on both channels
    int                          mismatches  = 0;
    int                          rand_items  = 0;
    swm_pkg::t_out_word          pending_medians[$];   // expected result words, oldest first

    // Predictor state: window contents in arrival order and in ascending order.
    logic [swm_pkg::WS_W-1:0]    win_reg = 7'd3;
    logic signed [31:0]          arrival_hist[swm_pkg::MAX_WINDOW];
    logic signed [31:0]          ordered_vals[$];
    int                          held_count = 0;
    int                          wr_slot    = 0;

    sliding_window_median_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_word     (i_in_word),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_word    (o_out_word)
    );

    always #2 i_clk = ~i_clk;

    // Hard stop in case the block hangs or a result never turns up.
    initial begin
        #(RUN_LIMIT_NS);
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Window size as the block uses it: zero acts as 1, anything above 64 saturates.
    function automatic int eff_window();
        if (win_reg == 0) begin
            return 1;
        end
        if (win_reg > swm_pkg::MAX_WINDOW) begin
            return swm_pkg::MAX_WINDOW;
        end
        return win_reg;
    endfunction

    // Advance the window by one accepted word and queue the result it causes, if any.
    task automatic predict_median(input logic signed [31:0] s, input logic last);
        int                 k;
        int                 old_slot;
        int                 i;
        logic signed [31:0] victim;
        logic signed [32:0] lo;
        logic signed [32:0] hi;
        swm_pkg::t_out_word r;
        k = eff_window();
        // Evict oldest words while full; after a shrink this drops the whole surplus.
        while (held_count >= k) begin
            old_slot = (wr_slot + swm_pkg::MAX_WINDOW - held_count) % swm_pkg::MAX_WINDOW;
            victim   = arrival_hist[old_slot];
            for (i = 0; i < ordered_vals.size(); i++) begin
                if (ordered_vals[i] == victim) begin
                    ordered_vals.delete(i);
                    break;
                end
            end
            held_count--;
        end
        i = 0;
        while (i < ordered_vals.size() && ordered_vals[i] <= s) begin
            i++;
        end
        ordered_vals.insert(i, s);
        arrival_hist[wr_slot] = s;
        held_count++;
        wr_slot = (wr_slot + 1) % swm_pkg::MAX_WINDOW;
        if (held_count == k) begin
            if (k % 2 == 1) begin
                lo = ordered_vals[(k - 1) / 2];
                hi = lo;
            end else begin
                lo = ordered_vals[k / 2 - 1];
                hi = ordered_vals[k / 2];
            end
            r.median_doubled = lo + hi;
            r.sequence_end   = last;
            pending_medians.insert(pending_medians.size(), r);
        end
        // Last word of a sequence empties the window whether or not a result came.
        if (last) begin
            held_count = 0;
            wr_slot    = 0;
            ordered_vals.delete();
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("mismatch at %0t ns: %s, got %0d, want %0d", $time, what, got, want);
        end
    endtask

    // Output words are taken at the rising edge; stall only changes on the falling edge.
    always @(posedge i_clk) begin : check_results
        swm_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_medians.size() == 0) begin
                report_mismatch("result word with none pending",
                                longint'(o_out_word.median_doubled), 0);
            end else begin
                want = pending_medians.pop_front();
                if (o_out_word.median_doubled !== want.median_doubled) begin
                    report_mismatch("median_doubled", longint'(o_out_word.median_doubled),
                                    longint'(want.median_doubled));
                end
                if (o_out_word.sequence_end !== want.sequence_end) begin
                    report_mismatch("sequence_end", longint'(o_out_word.sequence_end),
                                    longint'(want.sequence_end));
                end
            end
        end
    end

    // Receiver back-pressure: while gaps are on, stall is drawn high with a chance of 19 in 100.
    always @(negedge i_clk) begin
        i_out_stall <= gaps_on && ($urandom_range(99) < 19);
    end

    // ------------------------------------------------------------------
    // Drivers and helpers
    // ------------------------------------------------------------------

    // Offer one word and hold it until accepted. Valid is left high on return, so
    // the caller's next step must be another send_word or release_input.
    task automatic send_word(input logic signed [31:0] s, input logic last);
        swm_pkg::t_in_word w;
        w.sample      = s;
        w.last_sample = last;
        @(negedge i_clk);
        while (gaps_on && $urandom_range(99) < 19) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        predict_median(s, last);
    endtask

    task automatic release_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_results();
        while (pending_medians.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Block is idle once every result is out and a word with no result has had time to finish.
    task automatic wait_idle();
        release_input();
        wait_results();
        repeat (IDLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [swm_pkg::WS_W-1:0] v);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        win_reg = v;
    endtask

    // Mix of full-range values, tight clusters (plenty of duplicates) and extremes.
    function automatic logic signed [31:0] pick_sample();
        int t;
        case ($urandom_range(3))
            0: return $urandom;
            1: begin
                t = $urandom_range(8);
                return t - 4;
            end
            2: begin
                case ($urandom_range(3))
                    0: return SAMPLE_MAX;
                    1: return SAMPLE_MIN;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: return $urandom & 32'h8000_00FF;
        endcase
    endfunction

    // Mostly small windows, a quarter of the time an edge value (incl. 0 and saturating ones).
    function automatic logic [swm_pkg::WS_W-1:0] pick_window();
        if ($urandom_range(3) == 0) begin
            case ($urandom_range(6))
                0: return 7'd0;
                1: return 7'd1;
                2: return 7'd2;
                3: return 7'd63;
                4: return 7'd64;
                5: return 7'd65;
                default: return 7'd127;
            endcase
        end
        return swm_pkg::WS_W'($urandom_range(9, 1));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset window of 3: largest and smallest samples, the full doubled range,
    // then a sequence ended before the window fills (no result, window cleared).
    task automatic test_reset_window();
        send_word(SAMPLE_MAX, 1'b0);
        send_word(SAMPLE_MAX, 1'b0);
        send_word(SAMPLE_MAX, 1'b0);
        send_word(SAMPLE_MIN, 1'b0);
        send_word(SAMPLE_MIN, 1'b0);
        send_word(SAMPLE_MIN, 1'b1);
        send_word(32'sd5, 1'b0);
        send_word(32'sd7, 1'b1);
    endtask

    // Even window: result is the sum of the two middle words.
    task automatic test_even_window();
        wait_idle();
        write_window(7'd2);
        send_word(SAMPLE_MAX, 1'b0);
        send_word(SAMPLE_MIN, 1'b0);
        send_word(SAMPLE_MAX, 1'b0);
        send_word(-32'sd1, 1'b1);
    endtask

    // Window size zero behaves as a window of one.
    task automatic test_zero_window();
        wait_idle();
        write_window(7'd0);
        send_word(32'sd1, 1'b0);
        send_word(-32'sd1, 1'b1);
    endtask

    // Shrink from 5 to 2 with the sequence still open: surplus oldest words are evicted.
    task automatic test_window_shrink();
        wait_idle();
        write_window(7'd5);
        send_word(32'sd10, 1'b0);
        send_word(-32'sd3, 1'b0);
        send_word(32'sd7, 1'b0);
        send_word(32'sd7, 1'b0);
        send_word(32'sd0, 1'b0);
        wait_idle();
        write_window(7'd2);
        send_word(32'sd4, 1'b0);
        send_word(32'sd9, 1'b1);
    endtask

    // A long stretch with no idling on either side, words back to back.
    task automatic test_back_to_back();
        int n;
        int len;
        wait_idle();
        gaps_on = 1'b0;
        write_window(7'd7);
        n = 0;
        while (n < 150) begin
            len = $urandom_range(30, 5);
            repeat (len) begin
                n++;
                send_word(pick_sample(), n % len == 0 || n == 150);
            end
        end
        rand_items += n;
        release_input();
        gaps_on = 1'b1;
    endtask

    // Random phases, each with its own window size. Sequences are mostly long enough
    // to fill the window; some end early. A phase may leave its sequence open, so the
    // next size change lands mid-sequence (grow or shrink).
    task automatic test_random_phases();
        int phase;
        int target;
        int done;
        int k;
        int len;
        int j;
        bit open_end;
        bit is_final;
        phase = 0;
        while (rand_items < RAND_ITEMS) begin
            wait_idle();
            write_window(pick_window());
            k        = eff_window();
            target   = (2 * k + 10 > 90) ? 2 * k + 10 : 90;
            open_end = ($urandom_range(2) == 0);
            done     = 0;
            while (done < target) begin
                if ($urandom_range(99) < 15) begin
                    len = $urandom_range(k, 1);
                end else begin
                    len = $urandom_range(3 * k + 4, k);
                end
                is_final = (done + len >= target);
                for (j = 0; j < len; j++) begin
                    // Phase 0 always, others at random: sender waits mid-phase for all results.
                    if (done == target / 2 && (phase == 0 || $urandom_range(2) == 0)) begin
                        release_input();
                        wait_results();
                    end
                    send_word(pick_sample(), (j == len - 1) && !(is_final && open_end));
                    done++;
                end
            end
            rand_items += done;
            phase++;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------

    initial begin : run
        int n;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_window();
        test_even_window();
        test_zero_window();
        test_window_shrink();
        test_back_to_back();
        test_random_phases();

        // Drain: bounded wait for the last results, then allow for trailing work.
        release_input();
        n = 0;
        while (pending_medians.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (IDLE_CYCLES) @(posedge i_clk);
        if (pending_medians.size() != 0) begin
            report_mismatch("results never arrived", pending_medians.size(), 0);
        end

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/swm_pkg.sv
rtl/swm_ctrl.sv
rtl/swm_dp.sv
rtl/sliding_window_median_unit.sv
tb/sliding_window_median_unit_test.sv
